@@ rtl/core/ttli_pkg.sv @@
// Package for the time table linear interpolator.
// Holds default sizes, operation, status and state codes and register indexes.
`default_nettype none
package ttli_pkg;
  localparam int unsigned DefTableDepth = 1024;
  localparam int unsigned DefTimeBits   = 48;
  localparam int unsigned DefTempBits   = 16;
  localparam int unsigned CfgIdxBits    = 1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_GAP   = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  localparam logic [CfgIdxBits-1:0] CfgGapLimit  = 1'd0;
  localparam logic [CfgIdxBits-1:0] CfgGapEnable = 1'd1;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_LOAD, S_MUL, S_DIV, S_ROUND, S_OUT
  } state_e;
endpackage
`default_nettype wire

@@ rtl/core/time_table_linear_interpolator.sv @@
// Time table linear interpolator: a sample table in two block memories plus
// a scan sequencer and a bit-serial divider. Depends on ttli_pkg.
//
// An append, clear or unknown operation moves from S_IDLE to S_OUT on
// acceptance, and S_OUT sets the registered out_valid_o. The next item is
// accepted only once that result is taken, so no new item enters while a
// result waits. A query reads one table entry per cycle from entry 0 until
// it finds the first sample not earlier than the query time, or runs off the
// end of the table; an empty table reads no entry. Load, multiply, the
// restoring divider, rounding and output follow as S_LOAD, S_MUL, S_DIV,
// S_ROUND and S_OUT, and rejected queries take the same path. One item is in
// work at a time, and the memory read port sets the scan pace. The result
// register holds a finished item until it is taken. No clearing pass is
// needed.
`default_nettype none
module time_table_linear_interpolator #(
  parameter int unsigned TABLE_DEPTH = ttli_pkg::DefTableDepth,
  parameter int unsigned TIME_BITS   = ttli_pkg::DefTimeBits,
  parameter int unsigned TEMP_BITS   = ttli_pkg::DefTempBits,
  localparam int unsigned CntBits    = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned CfgBits    = TIME_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ttli_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [CfgBits-1:0]            cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    operation_i,
  input  wire logic [TIME_BITS-1:0]          point_time_i,
  input  wire logic [TEMP_BITS-1:0]          sample_temperature_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [TEMP_BITS-1:0]               temperature_o,
  output logic [1:0]                         status_o,
  output logic [CntBits-1:0]                 entry_count_o
);
  import ttli_pkg::*;

  localparam int unsigned AddrBits = $clog2(TABLE_DEPTH);
  localparam int unsigned ProdBits = TIME_BITS + TEMP_BITS;
  localparam int unsigned StepBits = $clog2(ProdBits + 1);
  localparam logic [CntBits-1:0] DepthC = CntBits'(TABLE_DEPTH);

  logic [TIME_BITS-1:0] time_mem [TABLE_DEPTH];
  logic [TEMP_BITS-1:0] temp_mem [TABLE_DEPTH];

  state_e state_q, state_d;
  logic [TIME_BITS-1:0] gap_limit_q;
  logic                 gap_en_q;
  logic [CntBits-1:0]   count_q;
  logic [CntBits-1:0]   idx_q;
  logic [TIME_BITS-1:0] qtime_q;
  logic [TIME_BITS-1:0] rd_time_q, ta_q;
  logic [TEMP_BITS-1:0] rd_temp_q, va_q, vb_q;
  logic                 rd_vld_q;
  logic [TIME_BITS-1:0] den_q, num_q;
  logic [TEMP_BITS-1:0] dlt_q;
  logic                 up_q;
  logic [ProdBits-1:0]  prod_q;
  logic [TIME_BITS:0]   rem_q;
  logic [TEMP_BITS-1:0] quo_q;
  logic [StepBits-1:0]  step_q;
  logic                 out_vld_q;
  logic [TEMP_BITS-1:0] out_temp_q;
  logic [1:0]           out_st_q;
  logic [CntBits-1:0]   out_cnt_q;

  logic                 in_fire;
  logic                 rd_en;
  logic [AddrBits-1:0]  rd_addr;
  logic                 hit;
  logic [TIME_BITS:0]   rem_sh, rem_sub;
  logic [TIME_BITS:0]   twice;
  logic                 rnd;
  logic [TEMP_BITS-1:0] quo_r;

  assign in_ready_o    = (state_q == S_IDLE) && !out_vld_q;
  assign in_fire       = in_valid_i && in_ready_o;
  assign out_valid_o   = out_vld_q;
  assign temperature_o = out_temp_q;
  assign status_o      = out_st_q;
  assign entry_count_o = out_cnt_q;

  // read address follows the scan index; read issued in scan state
  assign rd_addr = idx_q[AddrBits-1:0];
  assign rd_en   = (state_q == S_SCAN) && (idx_q < count_q);
  assign hit     = rd_vld_q && !(qtime_q > rd_time_q);

  always_ff @(posedge clk_i) begin
    if (in_fire && op_e'(operation_i) == OP_APPEND && count_q < DepthC) begin
      time_mem[count_q[AddrBits-1:0]] <= point_time_i;
      temp_mem[count_q[AddrBits-1:0]] <= sample_temperature_i;
    end
    if (rd_en) begin
      rd_time_q <= time_mem[rd_addr];
      rd_temp_q <= temp_mem[rd_addr];
    end
  end

  // divider step: shift in next product bit, subtract if it fits
  assign rem_sh  = {rem_q[TIME_BITS-1:0], prod_q[ProdBits-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign twice   = {rem_q[TIME_BITS-1:0], 1'b0};
  // round the delta half up when rising, half down when falling
  assign rnd     = up_q ? (twice >= {1'b0, den_q}) : (twice > {1'b0, den_q});
  assign quo_r   = quo_q + TEMP_BITS'(rnd);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire) state_d = (op_e'(operation_i) == OP_QUERY) ? S_SCAN : S_OUT;
      S_SCAN:  if (hit || (!rd_vld_q && !rd_en)) state_d = S_LOAD;
      S_LOAD:  state_d = S_MUL;
      S_MUL:   state_d = S_DIV;
      S_DIV:   if (step_q == StepBits'(ProdBits)) state_d = S_ROUND;
      S_ROUND: state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gap_limit_q <= '1;
      gap_en_q    <= 1'b0;
      count_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CfgGapLimit) gap_limit_q <= cfg_data_i;
        else if (cfg_index_i == CfgGapEnable) gap_en_q <= cfg_data_i[0];
      end
      rd_vld_q <= rd_en && !hit;
      if (out_vld_q && out_ready_i) out_vld_q <= 1'b0;
      if (in_fire) begin
        case (op_e'(operation_i))
          OP_CLEAR:  count_q <= '0;
          OP_APPEND: if (count_q < DepthC) count_q <= count_q + 1'b1;
          default:   ;
        endcase
      end
      if (state_q == S_OUT) out_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          qtime_q  <= point_time_i;
          idx_q    <= '0;
          out_temp_q <= '0;
          case (op_e'(operation_i))
            OP_CLEAR:  out_st_q <= ST_OK;
            OP_APPEND: out_st_q <= (count_q < DepthC) ? ST_OK : ST_FULL;
            OP_QUERY:  out_st_q <= ST_OK;
            default:   out_st_q <= ST_RANGE;
          endcase
        end
      end
      S_SCAN: begin
        if (rd_en && !hit) idx_q <= idx_q + 1'b1;
        if (rd_vld_q && !hit) begin
          ta_q <= rd_time_q;
          va_q <= rd_temp_q;
        end
        if (hit) begin
          vb_q  <= rd_temp_q;
          // idx_q has moved one past the hit entry
          den_q <= rd_time_q - ta_q;
          num_q <= qtime_q - ta_q;
          if (idx_q == CntBits'(1)) out_st_q <= ST_RANGE;
          else if (gap_en_q && (rd_time_q - ta_q) > gap_limit_q) out_st_q <= ST_GAP;
        end else if (!rd_vld_q && !rd_en) begin
          out_st_q <= ST_RANGE;
        end
      end
      S_LOAD: begin
        up_q  <= vb_q >= va_q;
        dlt_q <= (vb_q >= va_q) ? (vb_q - va_q) : (va_q - vb_q);
      end
      S_MUL: begin
        prod_q <= ProdBits'(num_q) * ProdBits'(dlt_q);
        rem_q  <= '0;
        quo_q  <= '0;
        step_q <= '0;
      end
      S_DIV: begin
        if (step_q != StepBits'(ProdBits)) begin
          prod_q <= {prod_q[ProdBits-2:0], 1'b0};
          step_q <= step_q + 1'b1;
          if (!rem_sub[TIME_BITS]) begin
            rem_q <= rem_sub;
            quo_q <= {quo_q[TEMP_BITS-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[TEMP_BITS-2:0], 1'b0};
          end
        end
      end
      S_ROUND: begin
        if (out_st_q == ST_OK)
          out_temp_q <= up_q ? (va_q + quo_r) : (va_q - quo_r);
      end
      S_OUT: out_cnt_q <= count_q;
      default: ;
    endcase
  end
endmodule
`default_nettype wire
